/* hdl/nearest_table_value_search_core_assert.svh */
// Assertion macros for the nearest table value search core.
// Both sample on clk and are switched off while rst is high.
`ifndef NEAREST_TABLE_VALUE_SEARCH_CORE_ASSERT_SVH
`define NEAREST_TABLE_VALUE_SEARCH_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define NTVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define NTVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ntvs_pkg.sv */
package ntvs_pkg;

  localparam int DATA_W      = 16;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = 9;
  localparam int INDEX_SPAN  = 256;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // query taken: latch target, read entry 0
    logic wr_en;     // write item taken
    logic compare;   // entry on the RAM output is valid for comparison
    logic load_out;  // copy best match into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;      // entry being compared is the final one in use
  } dp_status_t;

  function automatic logic [DATA_W-1:0] abs_gap(input logic [DATA_W-1:0] x,
                                                input logic [DATA_W-1:0] y);
    abs_gap = (x >= y) ? (x - y) : (y - x);
  endfunction

endpackage

/* hdl/nearest_table_value_search_core.sv */
// Nearest table value search core.
// Input stream (s_axis_*): tuser selects the item kind, 0 = write, 1 = query.
//   A write stores tdata's value at tdata's index and gives no result. A query
//   scans entries 0 .. N-1 of the table and returns the entry closest to the
//   target (earliest on a tie) with its index on m_axis_*.
// N is the cfg register (written over cfg_valid/cfg_ready, always ready), held
//   to 1 .. min(TABLE_DEPTH, 256); it is 256 after reset.
// Query flow: the table RAM has one registered read port and the scan reads
//   one entry per cycle, so a query holds the input off through its scan and
//   its finish state, and its result then goes to the output register.
// The output register frees the input side: a new item is taken while a result
//   is still waiting. A stalled receiver stalls the next query only at its end.
// Reset (synchronous, rst high) clears the control state and sets the count
//   register back to 256; table contents are kept undefined and must be written
//   before being searched.
`include "nearest_table_value_search_core_assert.svh"

module nearest_table_value_search_core #(
  parameter int TABLE_DEPTH = ntvs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] entry_index, [23:8] data_value
  input  logic [ntvs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] nearest_value, [23:16] nearest_index
  output logic [ntvs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ntvs_pkg::CNT_W-1:0]       cfg_data
);
  import ntvs_pkg::*;

  localparam int LIMIT = (TABLE_DEPTH < INDEX_SPAN) ? TABLE_DEPTH : INDEX_SPAN;

  ctrl_cmd_t         cmd;
  dp_status_t        stat;
  logic [DATA_W-1:0] out_value;
  logic [IDX_W-1:0]  out_index;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {out_index, out_value};

  ntvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_action(s_axis_tuser),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ntvs_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_index (s_axis_tdata[IDX_W-1:0]),
    .in_data  (s_axis_tdata[IDX_W+DATA_W-1:IDX_W]),
    .cmd      (cmd),
    .stat     (stat),
    .out_value(out_value),
    .out_index(out_index)
  );

  `NTVS_ASSERT_NEXT(a_busy_after_start, cmd.start, !s_axis_tready, "input open during scan")
  `NTVS_ASSERT_NEXT(a_scan_stops, cmd.compare && stat.last, !cmd.compare, "scan overran count")
  `NTVS_ASSERT_NEXT(a_result_shown, cmd.load_out, m_axis_tvalid, "loaded result not valid")
  `NTVS_ASSERT_NOW(a_index_range, m_axis_tvalid, 32'(out_index) < LIMIT, "index out of range")

endmodule

/* hdl/ntvs_ram.sv */
module ntvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ntvs_datapath.sv */
module ntvs_datapath #(
  parameter int TABLE_DEPTH = ntvs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [ntvs_pkg::CNT_W-1:0]  cfg_data,
  input  logic [ntvs_pkg::IDX_W-1:0]  in_index,
  input  logic [ntvs_pkg::DATA_W-1:0] in_data,
  input  ntvs_pkg::ctrl_cmd_t         cmd,
  output ntvs_pkg::dp_status_t        stat,
  output logic [ntvs_pkg::DATA_W-1:0] out_value,
  output logic [ntvs_pkg::IDX_W-1:0]  out_index
);
  import ntvs_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int LIMIT = (TABLE_DEPTH < INDEX_SPAN) ? TABLE_DEPTH : INDEX_SPAN;

  logic [CNT_W-1:0]  entries_in_use;
  logic [CNT_W-1:0]  scan_count;
  logic [IDX_W-1:0]  cmp_pos;
  logic [IDX_W-1:0]  next_pos;
  logic [DATA_W-1:0] target;
  logic [DATA_W-1:0] best_dist;
  logic [DATA_W-1:0] best_entry;
  logic [IDX_W-1:0]  best_idx;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] gap;
  logic [AW-1:0]     rd_addr;
  logic              wr_in_range;
  logic              take;

  // Count in use, held between 1 and the number of addressable entries
  always_comb begin
    if (entries_in_use == '0) begin
      scan_count = CNT_W'(1);
    end else if (entries_in_use > CNT_W'(LIMIT)) begin
      scan_count = CNT_W'(LIMIT);
    end else begin
      scan_count = entries_in_use;
    end
  end

  assign next_pos    = cmp_pos + 1'b1;
  assign rd_addr     = cmd.start ? '0 : AW'(next_pos);
  assign wr_in_range = 32'(in_index) < TABLE_DEPTH;
  assign stat.last   = ({1'b0, cmp_pos} == (scan_count - 1'b1));

  assign gap  = abs_gap(rd_data, target);
  // strict compare keeps the earliest entry on a tie
  assign take = (cmp_pos == '0) || (gap < best_dist);

  ntvs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.wr_en && wr_in_range),
    .waddr(AW'(in_index)),
    .wdata(in_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CNT_RESET;
    end else if (cfg_valid) begin
      entries_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target  <= in_data;
      cmp_pos <= '0;
    end else if (cmd.compare) begin
      cmp_pos <= next_pos;
    end
    if (cmd.compare && take) begin
      best_dist  <= gap;
      best_entry <= rd_data;
      best_idx   <= cmp_pos;
    end
    if (cmd.load_out) begin
      out_value <= best_entry;
      out_index <= best_idx;
    end
  end

endmodule

/* hdl/ntvs_ctrl.sv */
module ntvs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_action,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ntvs_pkg::ctrl_cmd_t   cmd,
  input  ntvs_pkg::dp_status_t  stat
);
  import ntvs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.start    = (state == ST_IDLE) && in_valid && (action_t'(in_action) == ACT_QUERY);
    cmd.wr_en    = (state == ST_IDLE) && in_valid && (action_t'(in_action) == ACT_WRITE);
    cmd.compare  = (state == ST_SCAN);
    cmd.load_out = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
